FILE: hw/rtl/tp20_receive_reassembler_defines.svh
// Assertion macros for the TP2.0 receive reassembler.
`ifndef TP20_RECEIVE_REASSEMBLER_DEFINES_SVH
`define TP20_RECEIVE_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TP20_ASSERT_HOLD(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tp20 assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TP20_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tp20 assertion failed");

`endif

FILE: hw/rtl/tp20_pkg.sv
// Shared types, codes and helpers of the TP2.0 receive reassembler.
package tp20_pkg;

	// Result codes on event_res.
	typedef enum logic [2:0] {
		EV_PAYLOAD = 3'd0,
		EV_ACK     = 3'd1,
		EV_TEST    = 3'd2,
		EV_DONE    = 3'd3,
		EV_FAIL    = 3'd4
	} ev_t;

	// Closing result of a plan.
	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_DONE = 2'd1,
		TAIL_FAIL = 2'd2
	} tail_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TEST_CODE  = 2'd0;
	localparam logic [1:0] CFG_ACK_CODE   = 2'd1;
	localparam logic [1:0] CFG_IDLE_LIMIT = 2'd2;
	localparam logic [1:0] CFG_BODY_LIMIT = 2'd3;

	// Frame type nibbles.
	localparam logic [3:0] TYPE_ACK_MORE  = 4'h0;
	localparam logic [3:0] TYPE_ACK_LAST  = 4'h1;
	localparam logic [3:0] TYPE_NACK_MORE = 4'h2;
	localparam logic [3:0] TYPE_NACK_LAST = 4'h3;

	// Wait frame signature.
	localparam logic [7:0] WAIT_B3 = 8'h7F;
	localparam logic [7:0] WAIT_B5 = 8'h78;
	localparam logic [3:0] ACK_HI  = 4'hB;

	localparam logic [2:0] SINGLE_MAX = 3'd5;
	localparam logic [2:0] TEST_MAX   = 3'd7;
	localparam logic [7:0] RCNT_SAT   = 8'd248;

	// One received input transaction.
	typedef struct packed {
		logic            kind;
		logic [7:0][7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] test_code;
		logic [7:0] ack_code;
		logic [2:0] idle_lim;
		logic [2:0] body_lim;
	} cfg_t;

	typedef struct packed {
		logic       in_msg;
		logic [7:0] exp_len;
		logic [7:0] rcnt;
		logic [2:0] tcnt;
	} state_t;

	// Results of one item: [test] payload*n [ack] [tail].
	typedef struct packed {
		logic            test;
		logic [7:0]      test_val;
		logic [6:0][7:0] pay;
		logic [2:0]      n_pay;
		logic            ack;
		logic [7:0]      ack_val;
		tail_t           tail;
		logic [7:0]      tail_len;
		logic [3:0]      total;
	} plan_t;

	// Ack byte: next sequence nibble under 0xB.
	function automatic logic [7:0] ack_byte(input logic [7:0] b0);
		ack_byte = {ACK_HI, b0[3:0] + 4'd1};
	endfunction

endpackage

FILE: hw/rtl/tp20_decode.sv
// Frame decoder: builds the result plan and next state for one item.
module tp20_decode import tp20_pkg::*; (
	input  item_t  item,
	input  state_t st,
	input  cfg_t   cfg,
	output plan_t  plan,
	output state_t st_next
);

	logic [3:0] ftype;
	logic [7:0] b0;
	logic [2:0] tc_inc;
	logic [2:0] lim;
	logic [7:0] diff;
	logic [6:0][7:0] pay_lo;
	logic [6:0][7:0] pay_hi;

	assign b0    = item.data[0];
	assign ftype = b0[7:4];

	// Payload windows: from byte3 (idle frames) or byte1 (message frames)
	always_comb begin
		pay_lo = '0;
		for (int i = 0; i < 5; i++) begin
			pay_lo[i] = item.data[i + 3];
		end
		for (int i = 0; i < 7; i++) begin
			pay_hi[i] = item.data[i + 1];
		end
	end

	assign tc_inc = (st.tcnt < TEST_MAX) ? st.tcnt + 3'd1 : TEST_MAX;
	assign lim    = st.in_msg ? cfg.body_lim : cfg.idle_lim;
	assign diff   = (st.exp_len > st.rcnt) ? st.exp_len - st.rcnt : 8'd0;

	// Frame classification
	always_comb begin
		plan          = '0;
		plan.test_val = cfg.ack_code;
		plan.ack_val  = ack_byte(b0);
		plan.tail     = TAIL_NONE;
		st_next       = st;
		if (item.kind) begin
			plan.tail = TAIL_FAIL;
			st_next   = '0;
		end else if (b0 == cfg.test_code) begin
			plan.test    = 1'b1;
			st_next.tcnt = tc_inc;
			if (tc_inc >= lim) begin
				plan.tail = TAIL_FAIL;
				st_next   = '0;
			end
		end else if (item.data[3] == WAIT_B3 && item.data[5] == WAIT_B5) begin
			st_next.tcnt = '0;
			plan.ack = (ftype == TYPE_ACK_LAST) && (st.in_msg || item.data[1] != 8'd0);
		end else if (!st.in_msg) begin
			if (ftype == TYPE_ACK_LAST || ftype == TYPE_NACK_LAST) begin
				// single frame
				plan.pay      = pay_lo;
				plan.n_pay    = (item.data[2] < {5'd0, SINGLE_MAX}) ?
				                item.data[2][2:0] : SINGLE_MAX;
				plan.ack      = (ftype == TYPE_ACK_LAST);
				plan.tail     = TAIL_DONE;
				plan.tail_len = item.data[2];
				st_next       = '0;
			end else if (ftype == TYPE_ACK_MORE || ftype == TYPE_NACK_MORE) begin
				// first frame opens a message
				plan.pay        = pay_lo;
				plan.n_pay      = SINGLE_MAX;
				plan.ack        = (ftype == TYPE_ACK_MORE);
				st_next.in_msg  = 1'b1;
				st_next.exp_len = item.data[2];
				st_next.rcnt    = {5'd0, SINGLE_MAX};
				st_next.tcnt    = '0;
			end else begin
				plan.tail = TAIL_FAIL;
				st_next   = '0;
			end
		end else if (ftype == TYPE_ACK_LAST || ftype == TYPE_NACK_LAST) begin
			// last frame, copy clamped to what is still owed
			plan.pay      = pay_hi;
			plan.n_pay    = (diff > 8'd7) ? 3'd7 : diff[2:0];
			plan.ack      = (ftype == TYPE_ACK_LAST);
			plan.tail     = TAIL_DONE;
			plan.tail_len = st.exp_len;
			st_next       = '0;
		end else begin
			// middle frame
			plan.pay     = pay_hi;
			plan.n_pay   = 3'd7;
			plan.ack     = (ftype == TYPE_ACK_MORE);
			st_next.tcnt = '0;
			st_next.rcnt = (st.rcnt > RCNT_SAT) ? 8'd255 : st.rcnt + 8'd7;
		end
		plan.total = {3'd0, plan.test} + {1'b0, plan.n_pay} + {3'd0, plan.ack}
		             + {3'd0, plan.tail != TAIL_NONE};
	end

endmodule

FILE: hw/rtl/tp20_emit.sv
// Result sequencer: holds one plan and hands out its results one per cycle while out_ready is high.
`include "tp20_receive_reassembler_defines.svh"
module tp20_emit import tp20_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  plan_t      plan,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [7:0] value,
	output logic [7:0] length,
	output logic       last
);

	plan_t      plan_q;
	logic       valid_q;
	logic [3:0] idx_q;
	logic [3:0] pos;
	ev_t        ev;

	assign out_valid = valid_q;
	assign pos       = idx_q - {3'd0, plan_q.test};
	assign last      = (idx_q == plan_q.total - 4'd1);
	assign event_res = ev;

	// Select the result at the current position
	always_comb begin
		ev     = EV_FAIL;
		value  = '0;
		length = '0;
		if (plan_q.test && idx_q == 4'd0) begin
			ev    = EV_TEST;
			value = plan_q.test_val;
		end else if (pos < {1'b0, plan_q.n_pay}) begin
			ev    = EV_PAYLOAD;
			value = plan_q.pay[pos[2:0]];
		end else if (plan_q.ack && pos == {1'b0, plan_q.n_pay}) begin
			ev    = EV_ACK;
			value = plan_q.ack_val;
		end else begin
			case (plan_q.tail)
				TAIL_DONE: begin
					ev     = EV_DONE;
					length = plan_q.tail_len;
				end
				default: ev = EV_FAIL;
			endcase
		end
	end

	// Plan payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= plan;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	`TP20_ASSERT_HOLD(a_idx_range, valid_q, idx_q < plan_q.total)
	`TP20_ASSERT_HOLD(a_tail_last, valid_q && (ev == EV_DONE || ev == EV_FAIL), last)
	`TP20_ASSERT_NEXT(a_step, valid_q && out_ready && !last, valid_q && idx_q == $past(idx_q) + 4'd1)

endmodule

FILE: hw/rtl/tp20_receive_reassembler.sv
// Top level of the TP2.0 receive reassembler.
// Input channel (in_valid/in_ready) takes one transaction per received CAN frame
// (kind = 0, byte0..byte7) or per receive timeout (kind = 1).
// Output channel (out_valid/out_ready) gives results: payload bytes, ack requests,
// test replies, done with the message length, failure; last marks the final one
// caused by a transaction. A transaction that causes no result gives nothing.
// An accepted transaction is registered, decoded against the session state once
// the result sequencer is free, and loaded as a plan into the sequencer, which
// hands out one result per cycle while out_ready is high; a transaction gives
// N (0..9) results; the next is decoded while the last of the previous is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// must make them only while idle, which the block itself does not enforce.
// Reset clears the session state and loads the register defaults.
// When the receiver stalls, the current result holds, one transaction waits in
// the input register, and in_ready drops.
module tp20_receive_reassembler import tp20_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] byte0,
	input  logic [7:0] byte1,
	input  logic [7:0] byte2,
	input  logic [7:0] byte3,
	input  logic [7:0] byte4,
	input  logic [7:0] byte5,
	input  logic [7:0] byte6,
	input  logic [7:0] byte7,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [7:0] value,
	output logic [7:0] length,
	output logic       last
);

	item_t  item_s1;
	logic   valid_s1;
	cfg_t   cfg_q;
	state_t st_q;
	state_t st_next;
	plan_t  plan;
	logic   emit_free;
	logic   go;

	assign emit_free = !out_valid || (out_ready && last);
	assign go        = valid_s1 && emit_free;
	assign in_ready  = !valid_s1 || go;

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= kind;
			item_s1.data <= {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
		end
	end

	// Input register, session state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			st_q            <= '0;
			cfg_q.test_code <= 8'd163;
			cfg_q.ack_code  <= 8'd161;
			cfg_q.idle_lim  <= 3'd5;
			cfg_q.body_lim  <= 3'd3;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				st_q <= st_next;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TEST_CODE:  cfg_q.test_code <= cfg_data;
					CFG_ACK_CODE:   cfg_q.ack_code  <= cfg_data;
					CFG_IDLE_LIMIT: cfg_q.idle_lim  <= cfg_data[2:0];
					CFG_BODY_LIMIT: cfg_q.body_lim  <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

	tp20_decode u_decode (
		.item    (item_s1),
		.st      (st_q),
		.cfg     (cfg_q),
		.plan    (plan),
		.st_next (st_next)
	);

	tp20_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && plan.total != 4'd0),
		.plan      (plan),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res),
		.value     (value),
		.length    (length),
		.last      (last)
	);

endmodule

FILE: bench/tb_tp20_receive_reassembler.sv
// Testbench for the TP2.0 receive reassembler: directed cases, register sweeps, random traffic.
`timescale 1ns / 1ps

module tb_tp20_receive_reassembler import tp20_pkg::*; ();

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 1000;
	localparam int BODY_BYTES    = 7;
	localparam int MAX_REPORTS   = 10;
	localparam logic [3:0] TYPE_UNKNOWN_LO = 4'h4;
	localparam logic [3:0] TYPE_UNKNOWN_HI = 4'hF;

	// One result as the block should present it
	typedef struct packed {
		ev_t        ev;
		logic [7:0] val;
		logic [7:0] len;
		logic       is_last;
	} result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] event_res;
	logic [7:0] value;
	logic [7:0] length;
	logic       last;

	// Register copies and session state of the predictor
	logic [7:0] reg_test_code;
	logic [7:0] reg_reply_code;
	logic [2:0] reg_idle_limit;
	logic [2:0] reg_body_limit;
	logic       sess_in_msg;
	logic [7:0] sess_exp_len;
	logic [7:0] sess_rcvd;
	logic [2:0] sess_tests;

	result_t owed_results[$];
	int      mismatches;
	int      frames_sent;
	int      stall_cycles;
	bit      no_gaps;

	tp20_receive_reassembler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.byte0     (byte0),
		.byte1     (byte1),
		.byte2     (byte2),
		.byte3     (byte3),
		.byte4     (byte4),
		.byte5     (byte5),
		.byte6     (byte6),
		.byte7     (byte7),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res),
		.value     (value),
		.length    (length),
		.last      (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver back-pressure
	always @(negedge clk) begin
		out_ready <= no_gaps || ($urandom_range(0, 99) >= 31);
	end

	function automatic result_t make_result(input ev_t ev, input logic [7:0] val,
			input logic [7:0] len);
		result_t r;
		r.ev = ev;
		r.val = val;
		r.len = len;
		r.is_last = 1'b0;
		return r;
	endfunction

	function automatic void clear_session();
		sess_in_msg = 1'b0;
		sess_exp_len = '0;
		sess_rcvd = '0;
		sess_tests = '0;
	endfunction

	// Works out the results of one accepted transaction and updates the session
	task automatic reassemble(input item_t it);
		logic [7:0] b [8];
		logic [3:0] ftype;
		logic [2:0] lim;
		logic [7:0] ack;
		int n;
		result_t batch[$];
		for (int i = 0; i < 8; i++)
			b[i] = it.data[i];
		ftype = b[0][7:4];
		ack = {ACK_HI, b[0][3:0] + 4'd1};
		if (it.kind) begin
			batch.push_back(make_result(EV_FAIL, '0, '0));
			clear_session();
		end else if (b[0] == reg_test_code) begin
			lim = sess_in_msg ? reg_body_limit : reg_idle_limit;
			batch.push_back(make_result(EV_TEST, reg_reply_code, '0));
			if (sess_tests < TEST_MAX)
				sess_tests++;
			if (sess_tests >= lim) begin
				batch.push_back(make_result(EV_FAIL, '0, '0));
				clear_session();
			end
		end else if (b[3] == WAIT_B3 && b[5] == WAIT_B5) begin
			// wait frame: ack only when asked for, and idle only with byte1 set
			sess_tests = '0;
			if (ftype == TYPE_ACK_LAST && (sess_in_msg || b[1] != '0))
				batch.push_back(make_result(EV_ACK, ack, '0));
		end else if (!sess_in_msg) begin
			if (ftype == TYPE_ACK_LAST || ftype == TYPE_NACK_LAST) begin
				n = (b[2] < SINGLE_MAX) ? int'(b[2]) : int'(SINGLE_MAX);
				for (int i = 0; i < n; i++)
					batch.push_back(make_result(EV_PAYLOAD, b[3 + i], '0));
				if (ftype == TYPE_ACK_LAST)
					batch.push_back(make_result(EV_ACK, ack, '0));
				batch.push_back(make_result(EV_DONE, '0, b[2]));
				clear_session();
			end else if (ftype == TYPE_ACK_MORE || ftype == TYPE_NACK_MORE) begin
				for (int i = 0; i < SINGLE_MAX; i++)
					batch.push_back(make_result(EV_PAYLOAD, b[3 + i], '0));
				if (ftype == TYPE_ACK_MORE)
					batch.push_back(make_result(EV_ACK, ack, '0));
				sess_in_msg = 1'b1;
				sess_exp_len = b[2];
				sess_rcvd = 8'(SINGLE_MAX);
				sess_tests = '0;
			end else begin
				batch.push_back(make_result(EV_FAIL, '0, '0));
				clear_session();
			end
		end else if (ftype == TYPE_ACK_LAST || ftype == TYPE_NACK_LAST) begin
			// closing frame: only what is still owed, at most one frame body
			n = (sess_exp_len > sess_rcvd) ? int'(sess_exp_len - sess_rcvd) : 0;
			if (n > BODY_BYTES)
				n = BODY_BYTES;
			for (int i = 0; i < n; i++)
				batch.push_back(make_result(EV_PAYLOAD, b[1 + i], '0));
			if (ftype == TYPE_ACK_LAST)
				batch.push_back(make_result(EV_ACK, ack, '0));
			batch.push_back(make_result(EV_DONE, '0, sess_exp_len));
			clear_session();
		end else begin
			for (int i = 1; i < 8; i++)
				batch.push_back(make_result(EV_PAYLOAD, b[i], '0));
			if (ftype == TYPE_ACK_MORE)
				batch.push_back(make_result(EV_ACK, ack, '0));
			sess_tests = '0;
			sess_rcvd = (sess_rcvd > RCNT_SAT) ? 8'hFF : sess_rcvd + 8'd7;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].is_last = 1'b1;
		foreach (batch[i])
			owed_results.push_back(batch[i]);
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// Output monitor
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: event %0d value %02h length %0d last %0d",
					event_res, value, length, last));
			end else begin
				want = owed_results.pop_front();
				if (event_res !== want.ev || value !== want.val || length !== want.len ||
						last !== want.is_last)
					flag_mismatch($sformatf({"result mismatch (exp/got): event %0d/%0d ",
						"value %02h/%02h length %0d/%0d last %0d/%0d"},
						want.ev, event_res, want.val, value, want.len, length,
						want.is_last, last));
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic item_t data_frame(input logic [3:0] ftype, input logic [3:0] seq,
			input logic [7:0] b2);
		item_t it;
		it.kind = 1'b0;
		for (int i = 0; i < 8; i++)
			it.data[i] = 8'($urandom_range(0, 255));
		it.data[0] = {ftype, seq};
		it.data[2] = b2;
		return it;
	endfunction

	function automatic item_t timeout_item();
		item_t it;
		it = data_frame(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
		it.kind = 1'b1;
		return it;
	endfunction

	function automatic item_t test_frame();
		item_t it;
		it = data_frame('0, '0, 8'($urandom_range(0, 255)));
		it.data[0] = reg_test_code;
		return it;
	endfunction

	function automatic item_t wait_frame(input logic [3:0] ftype, input logic [7:0] b1);
		item_t it;
		it = data_frame(ftype, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
		it.data[1] = b1;
		it.data[3] = WAIT_B3;
		it.data[5] = WAIT_B5;
		return it;
	endfunction

	// Presents one transaction and predicts once it is accepted
	task automatic send_item(input item_t it);
		if (!no_gaps && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < 31);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		byte0 <= it.data[0];
		byte1 <= it.data[1];
		byte2 <= it.data[2];
		byte3 <= it.data[3];
		byte4 <= it.data[4];
		byte5 <= it.data[5];
		byte6 <= it.data[6];
		byte7 <= it.data[7];
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		reassemble(it);
		frames_sent++;
		@(negedge clk);
	endtask

	// Holds the sender until every owed result has come, then lets the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(input logic [7:0] code_test, input logic [7:0] code_reply,
			input logic [2:0] lim_idle, input logic [2:0] lim_body);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TEST_CODE;
		cfg_data <= code_test;
		@(negedge clk);
		cfg_index <= CFG_ACK_CODE;
		cfg_data <= code_reply;
		@(negedge clk);
		cfg_index <= CFG_IDLE_LIMIT;
		cfg_data <= {5'd0, lim_idle};
		@(negedge clk);
		cfg_index <= CFG_BODY_LIMIT;
		cfg_data <= {5'd0, lim_body};
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_test_code = code_test;
		reg_reply_code = code_reply;
		reg_idle_limit = lim_idle;
		reg_body_limit = lim_body;
	endtask

	task automatic send_tests(input int count);
		repeat (count) send_item(test_frame());
	endtask

	// Connection test or wait frame slipped in between data frames
	task automatic maybe_interlude();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			send_item(test_frame());
		else if (pick < 20)
			send_item(wait_frame(4'($urandom_range(0, 3)),
				$urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255))));
	endtask

	// One message, mostly well formed; a few are cut short or overrun
	task automatic send_message();
		int len;
		int mids;
		int broken;
		logic [3:0] seq;
		seq = 4'($urandom_range(0, 15));
		broken = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 30) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 255) : $urandom_range(0, 5);
			send_item(data_frame($urandom_range(0, 1) ? TYPE_ACK_LAST : TYPE_NACK_LAST,
				seq, 8'(len)));
		end else begin
			len = $urandom_range(0, 60);
			mids = (len > 12) ? (len - 12 + 6) / 7 : 0;
			if (broken >= 12 && broken < 18)
				mids += $urandom_range(1, 3);
			send_item(data_frame($urandom_range(0, 1) ? TYPE_ACK_MORE : TYPE_NACK_MORE,
				seq, 8'(len)));
			if (broken < 6) begin
				maybe_interlude();
				send_item(timeout_item());
			end else begin
				for (int i = 0; i < mids; i++) begin
					seq++;
					maybe_interlude();
					send_item(data_frame($urandom_range(0, 1) ? TYPE_ACK_MORE : TYPE_NACK_MORE,
						seq, 8'($urandom_range(0, 255))));
				end
				// a dropped closing frame leaves the message open for the next one
				if (broken >= 18 || broken < 12) begin
					seq++;
					maybe_interlude();
					send_item(data_frame($urandom_range(0, 1) ? TYPE_ACK_LAST : TYPE_NACK_LAST,
						seq, 8'($urandom_range(0, 255))));
				end
			end
		end
	endtask

	// Reset defaults: each frame kind and each clamp at least once
	task automatic test_directed_cases();
		item_t it;
		it = '0;
		it.data[0] = {TYPE_ACK_LAST, 4'h0};
		send_item(it);
		send_item(data_frame(TYPE_NACK_LAST, 4'h3, 8'd3));
		it = '1;
		it.kind = 1'b0;
		it.data[0] = {TYPE_ACK_LAST, 4'hF};
		it.data[2] = 8'd5;
		send_item(it);
		send_item(data_frame(TYPE_NACK_LAST, 4'h7, 8'd255));
		// multi-frame with an odd type nibble used as a middle frame
		send_item(data_frame(TYPE_ACK_MORE, 4'h0, 8'd20));
		send_item(data_frame(TYPE_UNKNOWN_HI, 4'h1, 8'd0));
		send_item(data_frame(TYPE_ACK_MORE, 4'h2, 8'd0));
		send_item(data_frame(TYPE_ACK_LAST, 4'h3, 8'd0));
		// closing frame after the count is already reached
		send_item(data_frame(TYPE_NACK_MORE, 4'h4, 8'd5));
		send_item(data_frame(TYPE_NACK_LAST, 4'h5, 8'd0));
		// closing frame clamped to one frame body
		send_item(data_frame(TYPE_ACK_MORE, 4'hF, 8'd30));
		send_item(data_frame(TYPE_NACK_LAST, 4'h0, 8'd0));
		send_item(data_frame(TYPE_UNKNOWN_LO, 4'h0, 8'd0));
		send_item(data_frame(TYPE_UNKNOWN_HI, 4'hF, 8'd255));
		send_item(timeout_item());
		send_item(data_frame(TYPE_ACK_MORE, 4'h6, 8'd40));
		send_item(timeout_item());
		send_item(test_frame());
		send_item(wait_frame(TYPE_ACK_LAST, 8'd0));
		send_item(wait_frame(TYPE_ACK_LAST, 8'h55));
		send_item(wait_frame(TYPE_NACK_LAST, 8'h55));
		// inside a message: wait ack, then tests up to the body limit
		send_item(data_frame(TYPE_NACK_MORE, 4'h8, 8'd50));
		send_item(wait_frame(TYPE_ACK_LAST, 8'd0));
		send_tests(3);
	endtask

	// Long message that drives the byte count into saturation
	task automatic test_length_saturation();
		send_item(data_frame(TYPE_NACK_MORE, 4'h0, 8'd255));
		for (int i = 0; i < 36; i++)
			send_item(data_frame((i % 2) ? TYPE_ACK_MORE : TYPE_NACK_MORE, 4'(i + 1), 8'd0));
		send_item(data_frame(TYPE_ACK_LAST, 4'h5, 8'd0));
	endtask

	task automatic test_register_extremes();
		drain_results();
		write_config(8'h00, 8'hFF, 3'd1, 3'd7);
		send_tests(1);
		send_item(data_frame(TYPE_NACK_MORE, 4'h1, 8'd40));
		send_tests(7);
		repeat (4) send_message();
		drain_results();
		write_config(8'hFF, 8'h00, 3'd7, 3'd1);
		send_tests(7);
		send_item(data_frame(TYPE_ACK_MORE, 4'h2, 8'd40));
		send_tests(1);
		repeat (4) send_message();
	endtask

	task automatic test_random_traffic();
		int msgs;
		int phase_end;
		for (int p = 0; p < 4; p++) begin
			drain_results();
			write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)));
			no_gaps <= (p == 2);
			phase_end = frames_sent + 15;
			msgs = 0;
			while (frames_sent < phase_end) begin
				if (msgs % 8 == 7 || $urandom_range(0, 19) == 0)
					drain_results();
				if ($urandom_range(0, 99) < 6)
					send_item(timeout_item());
				else if ($urandom_range(0, 99) < 10)
					send_item(data_frame(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255))));
				else
					send_message();
				msgs++;
			end
		end
		no_gaps <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TEST_CODE;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		{byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7} = '0;
		out_ready = 1'b0;
		no_gaps = 1'b0;
		mismatches = 0;
		frames_sent = 0;
		stall_cycles = 0;
		reg_test_code = 8'hA3;
		reg_reply_code = 8'hA1;
		reg_idle_limit = 3'd5;
		reg_body_limit = 3'd3;
		clear_session();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_length_saturation();
		test_register_extremes();
		test_random_traffic();
		drain_results();
		if (mismatches == 0 && owed_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
